// File: src/ilac_pkg.sv
// ilac_pkg: shared types, constants and the step decode for the lever-arm compensator.
// Used by ilac_ctrl, ilac_datapath and the top level; depends on nothing.
package ilac_pkg;

    // Register indexes of the configuration port
    localparam logic [2:0] CFG_ROT_ROW0 = 3'd0;
    localparam logic [2:0] CFG_ROT_ROW1 = 3'd1;
    localparam logic [2:0] CFG_ROT_ROW2 = 3'd2;
    localparam logic [2:0] CFG_LEVER    = 3'd3;
    localparam logic [2:0] CFG_MODE     = 3'd4;
    localparam logic [2:0] CFG_TAU      = 3'd5;

    // Compensation modes
    localparam logic [1:0] MODE_ROT  = 2'd0;
    localparam logic [1:0] MODE_FULL = 2'd2;

    // Step schedule landmarks
    localparam logic [5:0] STEP_ROT_END  = 6'd17;
    localparam logic [5:0] STEP_CENT_END = 6'd29;
    localparam logic [5:0] STEP_EUL_BEG  = 6'd30;
    localparam logic [5:0] STEP_LAST     = 6'd41;
    localparam logic [5:0] DIV_LAST      = 6'd63;

    localparam logic [30:0] DT_CLAMP = 31'd1073741824;

    typedef enum logic [2:0] {
        A_G, A_A, A_W, A_F, A_DIFF, A_DTC
    } a_src_t;

    typedef enum logic [2:0] {
        B_ROT, B_R, B_V, B_MEGA, B_F
    } b_src_t;

    typedef enum logic [2:0] {
        FIN_NONE, FIN_W, FIN_ACC, FIN_V, FIN_CENT, FIN_NUM, FIN_EUL
    } fin_t;

    typedef struct packed {
        a_src_t     a_src;
        logic [1:0] a_idx;
        b_src_t     b_src;
        logic [1:0] b_row;
        logic [1:0] b_idx;
        logic       neg;
        fin_t       fin;
        logic [1:0] f_idx;
    } uop_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ACC, ST_DIV, ST_DIVW, ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic       capture;
        logic       mul_en;
        logic       acc_en;
        logic       div_step;
        logic       f_wr;
        logic       load_out;
        logic [5:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       euler_ok;
    } dp_status_t;

    // Decode one multiply-accumulate step of the schedule
    function automatic uop_t uop_decode(input logic [5:0] step);
        uop_t       op;
        logic [5:0] s;
        logic [5:0] base;
        logic [1:0] i;
        logic [1:0] j;
        logic [1:0] i1;
        logic [1:0] i2;
        op = '0;
        s = '0;
        base = '0;
        i = '0;
        j = '0;
        i1 = '0;
        i2 = '0;
        if (step < 6'd18) begin
            // matrix times vector: rate rows first, then acceleration rows
            s = (step < 6'd9) ? step : step - 6'd9;
            i = (s >= 6'd6) ? 2'd2 : ((s >= 6'd3) ? 2'd1 : 2'd0);
            j = 2'(s - ({4'b0, i} + {3'b0, i, 1'b0}));
            op.a_src = (step < 6'd9) ? A_G : A_A;
            op.a_idx = j;
            op.b_src = B_ROT;
            op.b_row = i;
            op.b_idx = j;
            op.f_idx = i;
            if (j == 2'd2)
                op.fin = (step < 6'd9) ? FIN_W : FIN_ACC;
            else
                op.fin = FIN_NONE;
        end
        else if (step >= 6'd30 && step < 6'd36) begin
            // filter numerator: rate change times 1e6 minus dt times f
            s = step - 6'd30;
            i = s[2:1];
            op.f_idx = i;
            op.b_idx = i;
            op.a_idx = i;
            if (!s[0]) begin
                op.a_src = A_DIFF;
                op.b_src = B_MEGA;
                op.fin = FIN_NONE;
            end
            else begin
                op.a_src = A_DTC;
                op.b_src = B_F;
                op.neg = 1'b1;
                op.fin = FIN_NUM;
            end
        end
        else begin
            // cross products: w x r, w x v, f x r
            if (step < 6'd24)
                base = 6'd18;
            else if (step < 6'd30)
                base = 6'd24;
            else
                base = 6'd36;
            s = step - base;
            i = s[2:1];
            case (i)
                2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
                2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
                default: begin i1 = 2'd0; i2 = 2'd1; end
            endcase
            op.a_src = (base == 6'd36) ? A_F : A_W;
            op.b_src = (base == 6'd24) ? B_V : B_R;
            op.f_idx = i;
            if (!s[0]) begin
                op.a_idx = i1;
                op.b_idx = i2;
                op.fin = FIN_NONE;
            end
            else begin
                op.a_idx = i2;
                op.b_idx = i1;
                op.neg = 1'b1;
                if (base == 6'd18)
                    op.fin = FIN_V;
                else if (base == 6'd24)
                    op.fin = FIN_CENT;
                else
                    op.fin = FIN_EUL;
            end
        end
        return op;
    endfunction

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7fffffff;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    // Right shift by 16, rounding half up
    function automatic logic signed [65:0] rnd16(input logic signed [65:0] v);
        return (v + 66'sd32768) >>> 16;
    endfunction

    // Right shift by 12, rounding half up
    function automatic logic signed [65:0] rnd12(input logic signed [65:0] v);
        return (v + 66'sd2048) >>> 12;
    endfunction

endpackage

// File: src/ilac_ctrl.sv
// ilac_ctrl: sequencer for the compensator; walks the step schedule and the divider.
// Depends on ilac_pkg; drives ilac_datapath through dp_cmd_t.
module ilac_ctrl
    import ilac_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    logic [5:0]  step_reg, step_next;
    logic [5:0]  dcnt_reg, dcnt_next;
    logic        out_valid_reg, out_valid_next;
    uop_t        op;
    logic        euler_en;
    logic        load;

    assign op = uop_decode(step_reg);
    assign euler_en = status.euler_ok && (status.mode == MODE_FULL);
    assign load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        step_next = step_reg;
        dcnt_next = dcnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL;
                    step_next = '0;
                end
            end
            ST_MUL:
                state_next = ST_ACC;
            ST_ACC:
            begin
                if (op.fin == FIN_NUM)
                begin
                    state_next = ST_DIV;
                    dcnt_next = '0;
                end
                else if ((step_reg == STEP_ROT_END && status.mode == MODE_ROT) ||
                         step_reg == STEP_CENT_END)
                begin
                    if (euler_en)
                    begin
                        state_next = ST_MUL;
                        step_next = STEP_EUL_BEG;
                    end
                    else
                        state_next = ST_DONE;
                end
                else if (step_reg == STEP_LAST)
                    state_next = ST_DONE;
                else
                begin
                    state_next = ST_MUL;
                    step_next = step_reg + 6'd1;
                end
            end
            ST_DIV:
            begin
                dcnt_next = dcnt_reg + 6'd1;
                if (dcnt_reg == DIV_LAST)
                    state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                state_next = ST_MUL;
                step_next = step_reg + 6'd1;
            end
            ST_DONE:
            begin
                if (load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Hold the result beat until the receiver takes it
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    // Outputs
    always_comb
    begin
        in_ready = (state_reg == ST_IDLE);
        out_valid = out_valid_reg;
        cmd.capture = in_valid && (state_reg == ST_IDLE);
        cmd.mul_en = (state_reg == ST_MUL);
        cmd.acc_en = (state_reg == ST_ACC);
        cmd.div_step = (state_reg == ST_DIV);
        cmd.f_wr = (state_reg == ST_DIVW);
        cmd.load_out = load;
        cmd.step = step_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg <= '0;
            dcnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg <= step_next;
            dcnt_reg <= dcnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: src/ilac_datapath.sv
// ilac_datapath: configuration, shared 33x33 multiplier with accumulator, serial divider,
// sample state and output registers. Depends on ilac_pkg; commanded by ilac_ctrl.
module ilac_datapath
    import ilac_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [59:0]        cfg_data,
    input  logic [62:0]        stamp_us,
    input  logic signed [31:0] gyro_x,
    input  logic signed [31:0] gyro_y,
    input  logic signed [31:0] gyro_z,
    input  logic signed [31:0] accel_x,
    input  logic signed [31:0] accel_y,
    input  logic signed [31:0] accel_z,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    output logic [62:0]        out_stamp_us,
    output logic signed [31:0] body_gyro_x,
    output logic signed [31:0] body_gyro_y,
    output logic signed [31:0] body_gyro_z,
    output logic signed [31:0] body_accel_x,
    output logic signed [31:0] body_accel_y,
    output logic signed [31:0] body_accel_z
);

    logic [53:0]        rot_reg [3];
    logic [59:0]        lever_reg;
    logic [1:0]         mode_reg;
    logic [19:0]        tau_reg;

    logic [62:0]        stamp_reg;
    logic signed [31:0] g_reg [3];
    logic signed [31:0] a_reg [3];
    logic               euler_ok_reg;
    logic [30:0]        dtc_reg;
    logic [30:0]        den_reg;

    logic signed [31:0] w_reg [3];
    logic signed [31:0] v_reg [3];
    logic signed [31:0] f_reg [3];
    logic signed [31:0] last_rate_reg [3];
    logic [62:0]        last_stamp_reg;
    logic               have_prev_reg;
    logic signed [63:0] acc_reg [3];
    logic signed [65:0] prod_reg;
    logic signed [65:0] mac_reg;
    logic [30:0]        rem_reg;
    logic [63:0]        quo_reg;
    logic               dneg_reg;

    logic [62:0]        ostamp_reg;
    logic signed [31:0] ogyro_reg [3];
    logic signed [31:0] oaccel_reg [3];

    uop_t               op;
    logic signed [32:0] a_op;
    logic signed [32:0] b_op;
    logic [17:0]        rot_chunk;
    logic [19:0]        lev_chunk;
    logic signed [65:0] sum;
    logic signed [65:0] mag;
    logic [62:0]        dt;
    logic [30:0]        tau_eff;
    logic [31:0]        trial;
    logic               ge;
    logic signed [65:0] qs;

    assign op = uop_decode(cmd.step);
    assign status.mode = mode_reg;
    assign status.euler_ok = euler_ok_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0] <= 54'd65536;
            rot_reg[1] <= 54'd65536 << 18;
            rot_reg[2] <= 54'd65536 << 36;
            lever_reg <= '0;
            mode_reg <= 2'd1;
            tau_reg <= 20'd7958;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROT_ROW0: rot_reg[0] <= cfg_data[53:0];
                CFG_ROT_ROW1: rot_reg[1] <= cfg_data[53:0];
                CFG_ROT_ROW2: rot_reg[2] <= cfg_data[53:0];
                CFG_LEVER:    lever_reg <= cfg_data;
                CFG_MODE:     mode_reg <= cfg_data[1:0];
                CFG_TAU:      tau_reg <= cfg_data[19:0];
                default:      ;
            endcase
        end
    end

    // Time step against the previous sample
    assign dt = stamp_us - last_stamp_reg;
    assign tau_eff = (tau_reg == 20'd0) ? 31'd1 : {11'b0, tau_reg};

    // Capture the sample beat
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            stamp_reg <= stamp_us;
            g_reg[0] <= gyro_x;
            g_reg[1] <= gyro_y;
            g_reg[2] <= gyro_z;
            a_reg[0] <= accel_x;
            a_reg[1] <= accel_y;
            a_reg[2] <= accel_z;
            dtc_reg <= (dt > 63'(DT_CLAMP)) ? DT_CLAMP : dt[30:0];
            den_reg <= ((dt > 63'(DT_CLAMP)) ? DT_CLAMP : dt[30:0]) + tau_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            euler_ok_reg <= 1'b0;
        else if (cmd.capture)
            euler_ok_reg <= have_prev_reg && (stamp_us > last_stamp_reg) && (dt > 63'd1);
    end

    // Select multiplier operands
    assign rot_chunk = rot_reg[op.b_row][18 * op.b_idx +: 18];
    assign lev_chunk = lever_reg[20 * op.b_idx +: 20];

    always_comb
    begin
        case (op.a_src)
            A_G:     a_op = {g_reg[op.a_idx][31], g_reg[op.a_idx]};
            A_A:     a_op = {a_reg[op.a_idx][31], a_reg[op.a_idx]};
            A_W:     a_op = {w_reg[op.a_idx][31], w_reg[op.a_idx]};
            A_F:     a_op = {f_reg[op.a_idx][31], f_reg[op.a_idx]};
            A_DIFF:  a_op = {w_reg[op.a_idx][31], w_reg[op.a_idx]} -
                            {last_rate_reg[op.a_idx][31], last_rate_reg[op.a_idx]};
            A_DTC:   a_op = {2'b00, dtc_reg};
            default: a_op = '0;
        endcase
        case (op.b_src)
            B_ROT:   b_op = {{15{rot_chunk[17]}}, rot_chunk};
            B_R:     b_op = {{13{lev_chunk[19]}}, lev_chunk};
            B_V:     b_op = {v_reg[op.b_idx][31], v_reg[op.b_idx]};
            B_MEGA:  b_op = 33'sd1000000;
            B_F:     b_op = {f_reg[op.b_idx][31], f_reg[op.b_idx]};
            default: b_op = '0;
        endcase
    end

    // Register the product
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= a_op * b_op;
    end

    assign sum = op.neg ? (mac_reg - prod_reg) : (mac_reg + prod_reg);
    assign mag = sum[65] ? -sum : sum;

    // Divider iteration: one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[63]};
    assign ge = (trial >= {1'b0, den_reg});
    assign qs = dneg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});

    // Accumulate, finish a term, divide
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_reg <= '0;
            have_prev_reg <= 1'b0;
            last_stamp_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                f_reg[k] <= '0;
                last_rate_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.acc_en)
            begin
                if (op.fin == FIN_NONE)
                    mac_reg <= sum;
                else
                    mac_reg <= '0;
            end
            if (cmd.f_wr)
                f_reg[op.f_idx] <= sat32({{34{f_reg[op.f_idx][31]}}, f_reg[op.f_idx]} + qs);
            if (cmd.load_out)
            begin
                have_prev_reg <= 1'b1;
                last_stamp_reg <= stamp_reg;
                for (int k = 0; k < 3; k++)
                    last_rate_reg[k] <= w_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_en)
        begin
            case (op.fin)
                FIN_W:    w_reg[op.f_idx] <= sat32(rnd16(sum));
                FIN_ACC:  acc_reg[op.f_idx] <= 64'(rnd16(sum));
                FIN_V:    v_reg[op.f_idx] <= sat32(rnd12(sum));
                FIN_CENT: acc_reg[op.f_idx] <= acc_reg[op.f_idx] - 64'(rnd16(sum));
                FIN_EUL:  acc_reg[op.f_idx] <= acc_reg[op.f_idx] - 64'(rnd12(sum));
                FIN_NUM:
                begin
                    dneg_reg <= sum[65];
                    rem_reg <= '0;
                    quo_reg <= mag[63:0] + {34'b0, den_reg[30:1]};
                end
                default:  ;
            endcase
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? 31'(trial - {1'b0, den_reg}) : trial[30:0];
            quo_reg <= {quo_reg[62:0], ge};
        end
    end

    // Output beat registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            ostamp_reg <= stamp_reg;
            for (int k = 0; k < 3; k++)
            begin
                ogyro_reg[k] <= w_reg[k];
                oaccel_reg[k] <= sat32({{2{acc_reg[k][63]}}, acc_reg[k]});
            end
        end
    end

    assign out_stamp_us = ostamp_reg;
    assign body_gyro_x = ogyro_reg[0];
    assign body_gyro_y = ogyro_reg[1];
    assign body_gyro_z = ogyro_reg[2];
    assign body_accel_x = oaccel_reg[0];
    assign body_accel_y = oaccel_reg[1];
    assign body_accel_z = oaccel_reg[2];

endmodule

// File: src/imu_lever_arm_compensator_core.sv
// imu_lever_arm_compensator_core: top level of the IMU lever-arm compensator.
// Depends on ilac_pkg, ilac_ctrl and ilac_datapath.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one IMU sample beat: stamp, gyro and
//   accel in Q16.16. Output channel (out_valid/out_ready) returns one beat per
//   sample: stamp, body-frame rate and compensated acceleration.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write only
//   while the block is idle.
// Processing (one sample at a time, one shared 33x33 multiplier,
//   one-bit-per-cycle divider) covers rotation only, centrifugal and full mode
//   with the Euler term; in_ready returns in the same cycle as the result beat.
//   The 64-step divider runs once per axis, for the Euler term only.
// Reset: configuration returns to identity rotation, zero lever arm, centrifugal
//   mode and tau 7958 us; the previous-sample history and filter state clear.
// Stall: a result waits in the output register; the next sample is accepted and
//   computed meanwhile, and its result holds in the datapath until the slot frees.
module imu_lever_arm_compensator_core
    import ilac_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [59:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [62:0]        stamp_us,
    input  logic signed [31:0] gyro_x,
    input  logic signed [31:0] gyro_y,
    input  logic signed [31:0] gyro_z,
    input  logic signed [31:0] accel_x,
    input  logic signed [31:0] accel_y,
    input  logic signed [31:0] accel_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [62:0]        out_stamp_us,
    output logic signed [31:0] body_gyro_x,
    output logic signed [31:0] body_gyro_y,
    output logic signed [31:0] body_gyro_z,
    output logic signed [31:0] body_accel_x,
    output logic signed [31:0] body_accel_y,
    output logic signed [31:0] body_accel_z
);

    dp_cmd_t    cmd;
    dp_status_t status;

    ilac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    ilac_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .stamp_us     (stamp_us),
        .gyro_x       (gyro_x),
        .gyro_y       (gyro_y),
        .gyro_z       (gyro_z),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .cmd          (cmd),
        .status       (status),
        .out_stamp_us (out_stamp_us),
        .body_gyro_x  (body_gyro_x),
        .body_gyro_y  (body_gyro_y),
        .body_gyro_z  (body_gyro_z),
        .body_accel_x (body_accel_x),
        .body_accel_y (body_accel_y),
        .body_accel_z (body_accel_z)
    );

endmodule

// File: src/ilac_checker.sv
// ilac_checker: port-level checks for the compensator top level, bound to it below.
// Depends only on the top level's ports.
module ilac_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [62:0]        out_stamp_us,
    input logic signed [31:0] body_gyro_x,
    input logic signed [31:0] body_accel_x
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_stamp_us) && $stable(body_gyro_x) &&
            $stable(body_accel_x))
        else $error("stalled result beat changed");

    // Drop ready while a sample is in work
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready)
        else $error("sample accepted while busy");

    // Advance a new result only out of the busy phase
    a_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without work");

endmodule

bind imu_lever_arm_compensator_core ilac_checker u_ilac_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_stamp_us (out_stamp_us),
    .body_gyro_x  (body_gyro_x),
    .body_accel_x (body_accel_x)
);
